FILE: hdl/wps_pkg.sv
// Package for the wildcard pattern search block.
// Holds sizes, codes and the job record passed from the front stage to the back stage.
// No dependencies.
`default_nettype none

package wps_pkg;

  // Pattern and character sizes
  localparam int PAT_LEN  = 16;
  localparam int IDX_W    = 4;
  localparam int CHAR_W   = 8;
  localparam int SYM_W    = 5;
  localparam int OFS_W    = (PAT_LEN > 1) ? $clog2(PAT_LEN) : 1;
  localparam logic [CHAR_W-1:0] WILDCARD = 8'd63;

  // Text and match limits
  localparam int MAX_TEXT    = 65536;
  localparam int TCNT_W      = $clog2(MAX_TEXT + 1);
  localparam int MAX_MATCHES = 1024;
  localparam int FCNT_W      = $clog2(MAX_MATCHES + 1);

  // Result field widths
  localparam int POS_W   = 16;
  localparam int TOTAL_W = 11;

  // Job queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic {
    CMD_PATTERN = 1'b0,
    CMD_TEXT    = 1'b1
  } cmd_e;

  typedef enum logic {
    KIND_MATCH = 1'b0,
    KIND_COUNT = 1'b1
  } kind_e;

  // One job: hits[j] means the window starting at base + j agrees
  typedef struct packed {
    logic [PAT_LEN-1:0] hits;
    logic [POS_W-1:0]   base;
    logic               fin;
  } job_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

FILE: hdl/wps_if.sv
// Channel interfaces of the wildcard pattern search block.
// wps_in_if carries command beats, wps_out_if carries result beats; uses wps_pkg.
`default_nettype none

interface wps_in_if
  import wps_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [IDX_W-1:0]  pattern_index;
  logic [CHAR_W-1:0] char_value;
  logic              last_char;

  modport source (output valid, cmd, pattern_index, char_value, last_char, input ready);
  modport sink   (input valid, cmd, pattern_index, char_value, last_char, output ready);
endinterface

interface wps_out_if
  import wps_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               result_kind;
  logic [POS_W-1:0]   match_position;
  logic [TOTAL_W-1:0] match_total;
  logic               final_flag;

  modport source (output valid, result_kind, match_position, match_total, final_flag,
                  input ready);
  modport sink   (input valid, result_kind, match_position, match_total, final_flag,
                  output ready);
endinterface

`default_nettype wire

FILE: hdl/wps_fifo.sv
// Short job queue between the front and back stages.
// Register array with read and write pointers; uses wps_pkg.
`default_nettype none

module wps_fifo
  import wps_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  wire job_t    push_job_i,
  input  wire logic    pop_i,
  output job_t         head_o,
  output q_stat_t      stat_o
);

  job_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  assign head_o       = mem_q[rd_ptr_q];
  assign stat_o.full  = (cnt_q == QCNT_W'(QDEPTH));
  assign stat_o.empty = (cnt_q == '0);

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/wps_front.sv
// Front stage: accepts command beats, keeps the pattern and text window,
// compares all window offsets in parallel and queues one job per text beat
// that hits or is last. Uses wps_pkg and wps_in_if.
`default_nettype none

module wps_front
  import wps_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  wps_in_if.sink    in_i,
  input  wire q_stat_t q_stat_i,
  output logic      push_o,
  output job_t      push_job_o
);

  logic [SYM_W-1:0]  pat_q  [PAT_LEN];
  logic              care_q [PAT_LEN];
  logic [SYM_W-1:0]  win_q  [PAT_LEN];
  logic [SYM_W-1:0]  win_cur [PAT_LEN];
  logic [TCNT_W-1:0] tcnt_q, tcnt_new;

  logic              fire;
  logic              pat_fire;
  logic              text_fire;
  logic              stored;
  logic [PAT_LEN-1:0] agree;
  logic [PAT_LEN-1:0] hits;

  assign in_i.ready = !q_stat_i.full;
  assign fire       = in_i.valid && in_i.ready;
  assign pat_fire   = fire && (in_i.cmd == CMD_PATTERN);
  assign text_fire  = fire && (in_i.cmd == CMD_TEXT);
  assign stored     = text_fire && (tcnt_q < TCNT_W'(MAX_TEXT));
  assign tcnt_new   = stored ? tcnt_q + 1'b1 : tcnt_q;

  // window after this beat's character, oldest entry at index 0
  always_comb begin
    for (int i = 0; i < PAT_LEN; i++) begin
      if (!stored) begin
        win_cur[i] = win_q[i];
      end else if (i == PAT_LEN - 1) begin
        win_cur[i] = in_i.char_value[SYM_W-1:0];
      end else begin
        win_cur[i] = win_q[(i + 1) % PAT_LEN];
      end
    end
  end

  // agree[p]: window shifted by p zero pad characters agrees with the pattern
  always_comb begin
    logic [SYM_W-1:0] sym;
    for (int p = 0; p < PAT_LEN; p++) begin
      agree[p] = 1'b1;
      for (int i = 0; i < PAT_LEN; i++) begin
        sym = (i + p < PAT_LEN) ? win_cur[(i + p) % PAT_LEN] : '0;
        if (care_q[i] && (sym != pat_q[i])) begin
          agree[p] = 1'b0;
        end
      end
    end
  end

  // hit mask: offset 0 is the new full window, the rest are padded windows
  always_comb begin
    hits[0] = stored && agree[0] && (int'(tcnt_new) >= PAT_LEN);
    for (int p = 1; p < PAT_LEN; p++) begin
      hits[p] = in_i.last_char && agree[p] && (int'(tcnt_new) + p >= PAT_LEN);
    end
  end

  assign push_o          = text_fire && ((hits != '0) || in_i.last_char);
  assign push_job_o.hits = hits;
  assign push_job_o.base = POS_W'(tcnt_new - TCNT_W'(PAT_LEN));
  assign push_job_o.fin  = in_i.last_char;

  // pattern, window and text count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PAT_LEN; i++) begin
        pat_q[i]  <= '0;
        care_q[i] <= 1'b0;
        win_q[i]  <= '0;
      end
      tcnt_q <= '0;
    end else begin
      if (pat_fire) begin
        for (int i = 0; i < PAT_LEN; i++) begin
          if (int'(in_i.pattern_index) == i) begin
            if (in_i.char_value == WILDCARD) begin
              pat_q[i]  <= '0;
              care_q[i] <= 1'b0;
            end else begin
              pat_q[i]  <= in_i.char_value[SYM_W-1:0];
              care_q[i] <= 1'b1;
            end
          end
        end
      end
      if (text_fire) begin
        if (in_i.last_char) begin
          for (int i = 0; i < PAT_LEN; i++) begin
            win_q[i] <= '0;
          end
          tcnt_q <= '0;
        end else begin
          for (int i = 0; i < PAT_LEN; i++) begin
            win_q[i] <= win_cur[i];
          end
          tcnt_q <= tcnt_new;
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/wps_back.sv
// Back stage: takes jobs from the queue, issues one result beat per cycle
// through a free output register, and keeps the match count and limit.
// Uses wps_pkg and wps_out_if.
`default_nettype none

module wps_back
  import wps_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire job_t    head_i,
  input  wire q_stat_t q_stat_i,
  output logic         pop_o,
  wps_out_if.source    out_o
);

  job_t              cur_q;
  logic              busy_q;
  logic [FCNT_W-1:0] found_q, found_d;

  logic               ovalid_q;
  logic               okind_q;
  logic [POS_W-1:0]   opos_q;
  logic [TOTAL_W-1:0] ototal_q;
  logic               ofin_q;

  logic               out_free;
  logic               limit;
  logic               step;
  logic [PAT_LEN-1:0] eff;
  logic [PAT_LEN-1:0] lowbit;
  logic [OFS_W-1:0]   sel;
  logic [PAT_LEN-1:0] hits_nxt;
  logic               fin_nxt;
  logic               emit_pos;
  logic               emit_cnt;
  logic               done;

  assign out_free = !ovalid_q || out_o.ready;
  assign limit    = (found_q >= FCNT_W'(MAX_MATCHES));
  assign step     = busy_q && out_free;
  assign eff      = limit ? '0 : cur_q.hits;
  assign lowbit   = eff & (~eff + 1'b1);

  // offset of the lowest pending hit
  always_comb begin
    sel = '0;
    for (int j = 0; j < PAT_LEN; j++) begin
      if (lowbit[j]) begin
        sel = OFS_W'(j);
      end
    end
  end

  // one step of the current job
  always_comb begin
    hits_nxt = eff;
    fin_nxt  = cur_q.fin;
    emit_pos = 1'b0;
    emit_cnt = 1'b0;
    found_d  = found_q;
    if (step) begin
      if (eff != '0) begin
        emit_pos = 1'b1;
        hits_nxt = eff & ~lowbit;
        found_d  = found_q + 1'b1;
      end else if (cur_q.fin) begin
        emit_cnt = 1'b1;
        fin_nxt  = 1'b0;
        found_d  = '0;
      end
    end
  end

  assign done  = step && (hits_nxt == '0) && !fin_nxt;
  assign pop_o = (!busy_q || done) && !q_stat_i.empty;

  // job register and match count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      found_q <= '0;
    end else begin
      found_q <= found_d;
      if (pop_o) begin
        busy_q <= 1'b1;
      end else if (done) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= head_i;
    end else if (step) begin
      cur_q.hits <= hits_nxt;
      cur_q.fin  <= fin_nxt;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (emit_pos || emit_cnt) begin
      ovalid_q <= 1'b1;
    end else if (out_o.ready) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_pos) begin
      okind_q  <= KIND_MATCH;
      opos_q   <= POS_W'(cur_q.base + POS_W'(sel));
      ototal_q <= '0;
      ofin_q   <= 1'b0;
    end else if (emit_cnt) begin
      okind_q  <= KIND_COUNT;
      opos_q   <= '0;
      ototal_q <= TOTAL_W'(found_q);
      ofin_q   <= 1'b1;
    end
  end

  assign out_o.valid          = ovalid_q;
  assign out_o.result_kind    = okind_q;
  assign out_o.match_position = opos_q;
  assign out_o.match_total    = ototal_q;
  assign out_o.final_flag     = ofin_q;

`ifndef ASSERT_OFF
  a_found_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q <= FCNT_W'(MAX_MATCHES))
    else $error("match count above limit");

  a_count_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_cnt |=> (found_q == '0))
    else $error("match count not cleared after count report");

  a_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> busy_q)
    else $error("job taken but back stage idle");
`endif

endmodule

`default_nettype wire

FILE: hdl/wildcard_pattern_search_top.sv
// Top level of the wildcard pattern search block.
// Instantiates wps_front, wps_fifo and wps_back; uses wps_pkg and wps_if.
`default_nettype none

// Load a 16-character pattern with cmd 0 beats ('?' is a wildcard), then
// stream text with cmd 1 beats; characters compare on their low 5 bits.
// Input beats are taken back to back as long as the four-entry job queue
// has room. Each text beat that hits, and each last beat, becomes one job;
// the back stage issues one result beat per cycle while the output accepts
// them: one per reported position (up to 16, none once the match limit is
// reached), plus a count report for a last beat. A queue full of such jobs
// is what holds off input; ordinary text with sparse matches runs at one
// character per cycle.

module wildcard_pattern_search_top
  import wps_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  wps_in_if.sink    in_i,
  wps_out_if.source out_o
);

  logic    push;
  job_t    push_job;
  logic    pop;
  job_t    head;
  q_stat_t q_stat;

  wps_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .push_job_o (push_job)
  );

  wps_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .pop_i      (pop),
    .head_o     (head),
    .stat_o     (q_stat)
  );

  wps_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head),
    .q_stat_i (q_stat),
    .pop_o    (pop),
    .out_o    (out_o)
  );

endmodule

`default_nettype wire

FILE: tb/tb_wildcard_pattern_search_top.sv
// Self-checking testbench for wildcard_pattern_search_top.
// Drives command beats, predicts match and count reports and checks each result beat.
// Depends on wps_pkg, wps_if and the top level only.
`timescale 1ns / 1ps

module tb_wildcard_pattern_search_top;
  import wps_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int LONG_HOLD = 300;
  localparam int RANDOM_BEATS = 90;
  localparam int CALM_BEATS = 30;

  typedef struct packed {
    cmd_e              cmd;
    logic [IDX_W-1:0]  idx;
    logic [CHAR_W-1:0] ch;
    logic              last;
  } cmd_beat_t;

  typedef struct packed {
    kind_e              kind;
    logic [POS_W-1:0]   pos;
    logic [TOTAL_W-1:0] total;
    logic               fin;
  } report_t;

  logic clk_i;
  logic rst_ni;

  wps_in_if  in_if ();
  wps_out_if out_if ();

  wildcard_pattern_search_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Beats waiting for the driver, reports waiting for the monitor
  cmd_beat_t pending_beats[$];
  report_t   expected_reports[$];

  // Predicted block state
  logic [SYM_W-1:0] pattern_sym [PAT_LEN];
  logic             pattern_care [PAT_LEN];
  logic [SYM_W-1:0] window_sym [PAT_LEN];
  int               chars_seen;
  int               hits_found;

  // Run bookkeeping
  int beats_queued;
  int beats_taken;
  int reports_checked;
  int searches_closed;
  int mismatches;
  int idle_odds;
  int long_hold_req;

  // Driver and receiver state
  cmd_beat_t sending;
  int        send_gap;
  int        stall_left;
  int        hold_left;
  int        hold_seen;

  // Monitor scratch
  cmd_beat_t taken;
  report_t   want;

  // Clock, plus known input levels from time zero
  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.cmd = CMD_PATTERN;
    in_if.pattern_index = '0;
    in_if.char_value = '0;
    in_if.last_char = 1'b0;
    out_if.ready = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic void shift_window(logic [SYM_W-1:0] sym);
    for (int i = 0; i < PAT_LEN - 1; i++) window_sym[i] = window_sym[i + 1];
    window_sym[PAT_LEN - 1] = sym;
  endfunction

  // Report a window start if it agrees on every care slot and the cap allows it
  function automatic void note_window(int start);
    report_t r;
    bit      agree;
    agree = 1'b1;
    for (int i = 0; i < PAT_LEN; i++) begin
      if (pattern_care[i] && window_sym[i] != pattern_sym[i]) agree = 1'b0;
    end
    if (start >= 0 && agree && hits_found < MAX_MATCHES) begin
      hits_found++;
      r.kind = KIND_MATCH;
      r.pos = start[POS_W-1:0];
      r.total = '0;
      r.fin = 1'b0;
      expected_reports.push_back(r);
    end
  endfunction

  function automatic void predict_search(cmd_beat_t b);
    report_t r;
    if (b.cmd == CMD_PATTERN) begin
      if (int'(b.idx) < PAT_LEN) begin
        pattern_care[b.idx] = (b.ch != WILDCARD);
        pattern_sym[b.idx] = (b.ch == WILDCARD) ? '0 : b.ch[SYM_W-1:0];
      end
    end else begin
      if (chars_seen < MAX_TEXT) begin
        chars_seen++;
        shift_window(b.ch[SYM_W-1:0]);
        note_window(chars_seen - PAT_LEN);
      end
      if (b.last) begin
        // tail windows see zero padding past the end of the text
        for (int pad = 1; pad < PAT_LEN; pad++) begin
          shift_window('0);
          note_window(chars_seen - PAT_LEN + pad);
        end
        r.kind = KIND_COUNT;
        r.pos = '0;
        r.total = hits_found[TOTAL_W-1:0];
        r.fin = 1'b1;
        expected_reports.push_back(r);
        for (int i = 0; i < PAT_LEN; i++) window_sym[i] = '0;
        chars_seen = 0;
        hits_found = 0;
      end
    end
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
      mismatches++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: presents pending beats, with random idle bursts
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.cmd <= CMD_PATTERN;
      in_if.pattern_index <= '0;
      in_if.char_value <= '0;
      in_if.last_char <= 1'b0;
      send_gap <= 0;
    end else if (!in_if.valid || in_if.ready) begin
      if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        in_if.valid <= 1'b0;
      end else if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
        send_gap <= $urandom_range(0, 8);
        in_if.valid <= 1'b0;
      end else if (pending_beats.size() != 0) begin
        sending = pending_beats.pop_front();
        in_if.valid <= 1'b1;
        in_if.cmd <= sending.cmd;
        in_if.pattern_index <= sending.idx;
        in_if.char_value <= sending.ch;
        in_if.last_char <= sending.last;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall bursts, plus a long hold-off on request
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      stall_left <= 0;
      hold_left <= 0;
      hold_seen <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_if.ready <= 1'b0;
    end else if (hold_seen != long_hold_req) begin
      hold_seen <= long_hold_req;
      hold_left <= LONG_HOLD;
      out_if.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_if.ready <= 1'b0;
    end else if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
      stall_left <= $urandom_range(0, 8);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on each accepted command beat, check each result beat
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        taken.cmd = cmd_e'(in_if.cmd);
        taken.idx = in_if.pattern_index;
        taken.ch = in_if.char_value;
        taken.last = in_if.last_char;
        predict_search(taken);
        beats_taken++;
      end
      if (out_if.valid && out_if.ready) begin
        reports_checked++;
        if (out_if.result_kind == KIND_COUNT) searches_closed++;
        if (expected_reports.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual kind %0d pos %0d total %0d",
                   $time, out_if.result_kind, out_if.match_position, out_if.match_total);
          mismatches++;
        end else begin
          want = expected_reports.pop_front();
          check_field("result_kind", want.kind, out_if.result_kind);
          check_field("match_position", want.pos, out_if.match_position);
          check_field("match_total", want.total, out_if.match_total);
          check_field("final_flag", want.fin, out_if.final_flag);
        end
      end
    end
  end

  // Watchdog
  initial begin : watchdog
    int unsigned cycles;
    for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge clk_i);
    $display("timeout after %0d cycles, %0d reports still outstanding",
             cycles, expected_reports.size());
    $display("status: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  task automatic push_beat(cmd_e c, int idx, int ch, bit last);
    cmd_beat_t b;
    b.cmd = c;
    b.idx = idx[IDX_W-1:0];
    b.ch = ch[CHAR_W-1:0];
    b.last = last;
    pending_beats.push_back(b);
    beats_queued++;
  endtask

  // Wait until every queued beat is taken and every report has arrived
  task automatic settle();
    while (beats_taken != beats_queued || expected_reports.size() != 0) @(posedge clk_i);
  endtask

  // Random character over a two-symbol alphabet, upper bits free
  function automatic int alpha_char();
    return ($urandom_range(0, 7) << SYM_W) | $urandom_range(0, 1);
  endfunction

  initial begin : stimulus
    int n;
    int rand_beats;

    for (int i = 0; i < PAT_LEN; i++) begin
      pattern_sym[i] = '0;
      pattern_care[i] = 1'b0;
      window_sym[i] = '0;
    end
    chars_seen = 0;
    hits_found = 0;
    beats_queued = 0;
    beats_taken = 0;
    reports_checked = 0;
    searches_closed = 0;
    mismatches = 0;
    long_hold_req = 0;
    idle_odds = 5;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset pattern is all wildcards: a one-char search still hits at 0 via padding
    push_beat(CMD_TEXT, 0, 255, 1'b1);

    // Care slots at both index ends, a wildcard, 127 and 255 folding to 31,
    // a care slot of value 0 that agrees with padding, and last_char on a load
    push_beat(CMD_PATTERN, 0, 65, 1'b0);
    push_beat(CMD_PATTERN, 1, WILDCARD, 1'b0);
    push_beat(CMD_PATTERN, 2, 127, 1'b0);
    push_beat(CMD_PATTERN, 3, 255, 1'b1);
    push_beat(CMD_PATTERN, 4, 128, 1'b0);
    push_beat(CMD_PATTERN, 15, 0, 1'b0);
    push_beat(CMD_TEXT, 0, 97, 1'b0);
    push_beat(CMD_TEXT, 0, 5, 1'b0);
    push_beat(CMD_TEXT, 0, 63, 1'b0);
    push_beat(CMD_TEXT, 0, 255, 1'b0);
    push_beat(CMD_TEXT, 0, 128, 1'b1);

    // Pattern survives the end of a search; window and counts start over
    push_beat(CMD_TEXT, 15, 161, 1'b0);
    push_beat(CMD_TEXT, 0, 200, 1'b0);
    push_beat(CMD_TEXT, 0, 95, 1'b0);
    push_beat(CMD_TEXT, 0, 223, 1'b0);
    push_beat(CMD_TEXT, 0, 96, 1'b1);

    // Care slot turned back into a wildcard
    push_beat(CMD_PATTERN, 0, WILDCARD, 1'b0);
    push_beat(CMD_TEXT, 0, 0, 1'b0);
    push_beat(CMD_TEXT, 0, 1, 1'b1);
    settle();

    // Back pressure: all-wildcard pattern, hit-heavy searches under a long hold
    for (int i = 0; i < PAT_LEN; i++) push_beat(CMD_PATTERN, i, WILDCARD, 1'b0);
    long_hold_req <= long_hold_req + 1;
    for (int s = 0; s < 6; s++) begin
      n = $urandom_range(1, 8);
      for (int i = 0; i < n; i++) push_beat(CMD_TEXT, 0, $urandom_range(0, 255), i == n - 1);
    end
    settle();

    // Random part: mostly pattern tweaks followed by one short search, some noise
    idle_odds = 6;
    rand_beats = 0;
    while (rand_beats < RANDOM_BEATS) begin
      if (idle_odds != 0 && rand_beats >= RANDOM_BEATS - CALM_BEATS) begin
        while (beats_taken != beats_queued) @(posedge clk_i);
        idle_odds = 0;
      end
      if ($urandom_range(0, 4) == 0) begin
        push_beat(cmd_e'($urandom_range(0, 1)), $urandom_range(0, 15),
                  $urandom_range(0, 255), $urandom_range(0, 1));
        rand_beats++;
      end else begin
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) begin
          push_beat(CMD_PATTERN, $urandom_range(0, 15),
                    ($urandom_range(0, 3) == 0) ? alpha_char() : WILDCARD, 1'b0);
        end
        rand_beats += n;
        n = $urandom_range(1, 24);
        for (int i = 0; i < n; i++) push_beat(CMD_TEXT, $urandom_range(0, 15), alpha_char(),
                                             i == n - 1);
        rand_beats += n;
      end
    end
    settle();
    repeat (40) @(posedge clk_i);

    $display("checked %0d result beats over %0d closed searches from %0d command beats",
             reports_checked, searches_closed, beats_taken);
    $display("covered wildcard and care loads, folded high bits, padded tails, %s",
             "and back-to-back beats under a long output hold-off");
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/wps_pkg.sv
hdl/wps_if.sv
hdl/wps_fifo.sv
hdl/wps_front.sv
hdl/wps_back.sv
hdl/wildcard_pattern_search_top.sv
tb/tb_wildcard_pattern_search_top.sv
